// ===== sv/gcdlcm_pkg.sv =====
// Shared types and constants for the GCD/LCM block.
package gcdlcm_pkg;

	// Field widths of the result ports
	localparam int DIV_FIELD_BITS  = 31;
	localparam int MULT_FIELD_BITS = 62;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GCD,
		ST_DIV,
		ST_MUL,
		ST_DONE
	} gcdlcm_state_t;

endpackage

// ===== sv/gcd_lcm_trial_division.sv =====
// GCD and LCM of two operands on a shared subtract/shift unit.
//
// Usage:
//   Present first_operand / second_operand and pulse start while busy is low;
//   that edge is the input transfer. busy stays high until the result is out.
//   The result (divisor_result, multiple_result, bad_operand) is shown for
//   exactly one cycle with done high; the receiver must take it then.
//   Operand bits at or above OPERAND_BITS are ignored.
//   A zero operand sets bad_operand and returns zero for both values.
// Sequence (W = OPERAND_BITS):
//   GCD phase: binary (shift/subtract) GCD, one step per cycle, the number
//   of steps data dependent.
//   Quotient phase: restoring division first_operand / gcd, one quotient bit
//   per step over the W bits.
//   Product phase: one W x W multiply into prod_q; then ST_DONE shows the result.
//   A zero operand goes from ST_IDLE straight to ST_DONE, skipping the phases above.
//   The shared subtractor serves both the GCD steps and the division.
//   One item at a time; a new start is taken once busy drops.
// Reset:
//   arst_n clears the sequencer to idle; no result is pending after reset.
module gcd_lcm_trial_division #(
	parameter int OPERAND_BITS = 31
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic [gcdlcm_pkg::DIV_FIELD_BITS-1:0]  first_operand,
	input  logic [gcdlcm_pkg::DIV_FIELD_BITS-1:0]  second_operand,
	output logic                                   done,
	output logic [gcdlcm_pkg::DIV_FIELD_BITS-1:0]  divisor_result,
	output logic [gcdlcm_pkg::MULT_FIELD_BITS-1:0] multiple_result,
	output logic                                   bad_operand
);
	import gcdlcm_pkg::*;

	localparam int W   = OPERAND_BITS;
	localparam int CW  = $clog2(W);
	localparam int IW  = (W > DIV_FIELD_BITS) ? W : DIV_FIELD_BITS;
	localparam int GW  = (W > DIV_FIELD_BITS) ? W : DIV_FIELD_BITS;
	localparam int PW  = (2 * W > MULT_FIELD_BITS) ? 2 * W : MULT_FIELD_BITS;
	localparam logic [CW-1:0] LAST_BIT = CW'(W - 1);

	gcdlcm_state_t state_q, state_d;

	// Operands masked to the working width
	logic [IW-1:0] first_ext, second_ext;
	logic [W-1:0]  op_a, op_b;
	logic          in_zero;

	assign first_ext  = IW'(first_operand);
	assign second_ext = IW'(second_operand);
	assign op_a       = first_ext[W-1:0];
	assign op_b       = second_ext[W-1:0];
	assign in_zero    = (op_a == '0) || (op_b == '0);

	// Datapath registers
	logic [W-1:0]   x_q, y_q;      // GCD working pair
	logic [CW-1:0]  k_q;           // common factors of two
	logic [W-1:0]   quo_q;         // dividend in, quotient out
	logic [W-1:0]   b_q;           // second operand for the product
	logic [W-1:0]   g_q;           // gcd
	logic [W:0]     rem_q;         // division remainder
	logic [CW-1:0]  cnt_q;         // division bit counter
	logic [2*W-1:0] prod_q;        // lcm
	logic           bad_q;

	// Shared subtractor: GCD compare/subtract or division trial subtract
	logic [W:0]   sub_a, sub_b;
	logic [W+1:0] sub_r;
	logic         borrow;
	logic [W:0]   shifted_rem;

	assign shifted_rem = {rem_q[W-1:0], quo_q[W-1]};

	always_comb begin
		if (state_q == ST_DIV) begin
			sub_a = shifted_rem;
			sub_b = {1'b0, g_q};
		end else begin
			sub_a = {1'b0, x_q};
			sub_b = {1'b0, y_q};
		end
	end

	assign sub_r  = {1'b0, sub_a} - {1'b0, sub_b};
	assign borrow = sub_r[W+1];

	logic gcd_equal;
	assign gcd_equal = (sub_r == '0);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = in_zero ? ST_DONE : ST_GCD;
				end
			end
			ST_GCD: begin
				if (gcd_equal) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (cnt_q == '0) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL:  state_d = ST_DONE;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		busy = 1'b1;
		done = 1'b0;
		unique case (state_q)
			ST_IDLE: busy = 1'b0;
			ST_DONE: done = 1'b1;
			default: busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				x_q    <= op_a;
				y_q    <= op_b;
				quo_q  <= op_a;
				b_q    <= op_b;
				k_q    <= '0;
				bad_q  <= in_zero;
				g_q    <= '0;
				prod_q <= '0;
			end
			ST_GCD: begin
				if (gcd_equal) begin
					g_q   <= x_q << k_q;
					rem_q <= '0;
					cnt_q <= LAST_BIT;
				end else if (!x_q[0] && !y_q[0]) begin
					x_q <= x_q >> 1;
					y_q <= y_q >> 1;
					k_q <= k_q + 1'b1;
				end else if (!x_q[0]) begin
					x_q <= x_q >> 1;
				end else if (!y_q[0]) begin
					y_q <= y_q >> 1;
				end else if (!borrow) begin
					x_q <= sub_r[W-1:0];
				end else begin
					y_q <= W'(~sub_r[W-1:0] + 1'b1);
				end
			end
			ST_DIV: begin
				// restoring step: one quotient bit per cycle
				if (!borrow) begin
					rem_q <= sub_r[W:0];
				end else begin
					rem_q <= shifted_rem;
				end
				quo_q <= {quo_q[W-2:0], ~borrow};
				cnt_q <= cnt_q - 1'b1;
			end
			ST_MUL: begin
				prod_q <= (2*W)'(quo_q) * (2*W)'(b_q);
			end
			default: begin
			end
		endcase
	end

	// Result ports at the field widths
	logic [GW-1:0] g_ext;
	logic [PW-1:0] p_ext;

	assign g_ext           = GW'(g_q);
	assign p_ext           = PW'(prod_q);
	assign divisor_result  = g_ext[DIV_FIELD_BITS-1:0];
	assign multiple_result = p_ext[MULT_FIELD_BITS-1:0];
	assign bad_operand     = bad_q;

endmodule

// ===== sim/gcd_lcm_trial_division_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the GCD/LCM block: directed operand table, then random pairs.
module gcd_lcm_trial_division_test;
	import gcdlcm_pkg::*;

	// Extra wait after the last drain, scaled with the operand width
	localparam int OP_BITS        = DIV_FIELD_BITS;
	localparam int LATENCY_CYCLES = 5 * OP_BITS;
	localparam int RANDOM_PAIRS   = 122;
	// ~140 pairs plus idle gaps fit well inside this watchdog limit; keep a wide margin
	localparam int CYCLE_LIMIT    = 200000;
	localparam int REPORT_LIMIT   = 10;

	typedef logic [DIV_FIELD_BITS-1:0] operand_t;

	// One result transfer as the block shows it
	typedef struct packed {
		operand_t                   divisor;
		logic [MULT_FIELD_BITS-1:0] multiple;
		logic                       bad;
	} gcd_lcm_t;

	// Directed row; typed = 1 means the result below is used as is,
	// otherwise the result comes from the local GCD/LCM computation.
	typedef struct packed {
		operand_t first;
		operand_t second;
		logic     typed;
		gcd_lcm_t result;
	} operand_row_t;

	localparam operand_t OP_MAX    = '1;
	localparam operand_t BIT30     = operand_t'(1) << 30;
	localparam gcd_lcm_t COMPUTED  = '0;
	localparam gcd_lcm_t ZERO_FLAG = '{'0, '0, 1'b1};
	localparam gcd_lcm_t ONE_ONE   = '{31'd1, 62'd1, 1'b0};
	localparam gcd_lcm_t MAX_MAX   = '{OP_MAX, {31'd0, OP_MAX}, 1'b0};
	localparam gcd_lcm_t ONE_MAX   = '{31'd1, {31'd0, OP_MAX}, 1'b0};

	// Extremes, zero operands, equal operands, then a few shapes worth a look:
	// near-max coprime pair (largest product), powers of two, textbook pairs,
	// alternating bit patterns.
	localparam operand_row_t DIRECTED_ROWS [18] = '{
		'{31'd0,          31'd0,          1'b1, ZERO_FLAG},
		'{31'd0,          31'd1,          1'b1, ZERO_FLAG},
		'{OP_MAX,         31'd0,          1'b1, ZERO_FLAG},
		'{31'd0,          OP_MAX,         1'b1, ZERO_FLAG},
		'{31'd1,          31'd1,          1'b1, ONE_ONE},
		'{OP_MAX,         OP_MAX,         1'b1, MAX_MAX},
		'{31'd1,          OP_MAX,         1'b1, ONE_MAX},
		'{OP_MAX,         31'd1,          1'b1, ONE_MAX},
		'{31'd12345,      31'd12345,      1'b1, '{31'd12345, 62'd12345, 1'b0}},
		'{OP_MAX,         OP_MAX - 31'd1, 1'b0, COMPUTED},
		'{BIT30,          BIT30 >> 1,     1'b0, COMPUTED},
		'{BIT30,          31'd3,          1'b0, COMPUTED},
		'{31'd12,         31'd18,         1'b0, COMPUTED},
		'{31'd1071,       31'd462,        1'b0, COMPUTED},
		'{31'd97,         31'd89,         1'b0, COMPUTED},
		'{31'h5555_5555,  31'h2AAA_AAAA,  1'b0, COMPUTED},
		'{OP_MAX,         BIT30,          1'b0, COMPUTED},
		'{31'd2,          31'd4,          1'b0, COMPUTED}
	};

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       start;
	logic                       busy;
	operand_t                   first_operand;
	operand_t                   second_operand;
	logic                       done;
	operand_t                   divisor_result;
	logic [MULT_FIELD_BITS-1:0] multiple_result;
	logic                       bad_operand;

	gcd_lcm_t pending_results [$];
	int       mismatches  = 0;
	int       cycle_count = 0;
	bit       idling_on   = 1'b1;

	gcd_lcm_trial_division u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.first_operand   (first_operand),
		.second_operand  (second_operand),
		.done            (done),
		.divisor_result  (divisor_result),
		.multiple_result (multiple_result),
		.bad_operand     (bad_operand)
	);

	// 2 ns period
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// GCD by Euclid's remainder loop; LCM as (a / gcd) * b at double width,
	// which is exact and never overflows 2*W bits.
	function automatic gcd_lcm_t gcd_lcm_of(operand_t a, operand_t b);
		operand_t                   x;
		operand_t                   y;
		operand_t                   r;
		logic [MULT_FIELD_BITS-1:0] quotient;
		gcd_lcm_t                   res;
		res = '0;
		if (a == '0 || b == '0) begin
			res.bad = 1'b1;
			return res;
		end
		x = a;
		y = b;
		while (y != '0) begin
			r = x % y;
			x = y;
			y = r;
		end
		quotient     = MULT_FIELD_BITS'(a / x);
		res.divisor  = x;
		res.multiple = quotient * MULT_FIELD_BITS'(b);
		return res;
	endfunction

	// Called at a rising edge. Optional idle cycles, then hold start until the
	// block takes the pair (start high, busy low at the edge). start is left
	// high on return so back-to-back pairs need no dip.
	task automatic send_operands(input operand_t a, input operand_t b, input gcd_lcm_t want);
		while (idling_on && $urandom_range(99) < 22) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start          <= 1'b1;
		first_operand  <= a;
		second_operand <= b;
		do @(posedge clk); while (busy);
		pending_results.push_back(want);
	endtask

	// Stop sending and wait until every outstanding result has come back.
	// At least one edge passes, so start is never lowered and raised in one step.
	task automatic drain_results();
		start <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	// Result checker: done marks a one-cycle result transfer, taken at the
	// edge that ends it. Compared against the oldest outstanding expectation.
	always @(posedge clk) begin
		gcd_lcm_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected result transfer: divisor %0d multiple %0d bad %0b",
						divisor_result, multiple_result, bad_operand);
			end else begin
				want = pending_results.pop_front();
				if (divisor_result !== want.divisor || multiple_result !== want.multiple ||
						bad_operand !== want.bad) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display({"result mismatch: expected divisor %0d multiple %0d ",
							"bad %0b, got %0d %0d %0b"},
							want.divisor, want.multiple, want.bad,
							divisor_result, multiple_result, bad_operand);
				end
			end
		end
	end

	// Watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAILURE");
		$finish;
	end

	// Stimulus
	initial begin
		operand_row_t row;
		gcd_lcm_t     want;
		operand_t     a;
		operand_t     b;
		operand_t     g;
		int           kind;
		int           sel;

		arst_n         <= 1'b0;
		start          <= 1'b0;
		first_operand  <= '0;
		second_operand <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed table
		foreach (DIRECTED_ROWS[i]) begin
			row  = DIRECTED_ROWS[i];
			want = row.typed ? row.result : gcd_lcm_of(row.first, row.second);
			send_operands(row.first, row.second, want);
		end

		// Hold off until the block is empty before the random part
		drain_results();

		for (int i = 0; i < RANDOM_PAIRS; i++) begin
			// Long stretch with back-to-back transfers in the middle
			idling_on = !(i >= 40 && i < 80);
			// Second full drain mid-run
			if (i == 100)
				drain_results();

			kind = $urandom_range(99);
			if (kind < 30) begin
				// Full-range values: every operand bit toggles
				a = operand_t'($urandom());
				b = operand_t'($urandom());
			end else if (kind < 60) begin
				// Shared factor of random size, so the GCD is not trivially 1
				g = operand_t'($urandom_range(1, 1 << $urandom_range(0, 20)));
				a = operand_t'(g * $urandom_range(1, 1023));
				b = operand_t'(g * $urandom_range(1, 1023));
			end else if (kind < 70) begin
				a = operand_t'($urandom_range(1, 64));
				b = operand_t'($urandom_range(1, 64));
			end else if (kind < 78) begin
				// Zero in one or both operands
				a   = operand_t'($urandom());
				b   = operand_t'($urandom());
				sel = $urandom_range(2);
				if (sel != 1)
					a = '0;
				if (sel != 0)
					b = '0;
			end else if (kind < 85) begin
				a = operand_t'($urandom());
				b = a;
			end else begin
				// Power-of-two heavy values exercise the shift steps
				a = operand_t'($urandom_range(1, 255)) << $urandom_range(0, 23);
				b = operand_t'($urandom_range(1, 255)) << $urandom_range(0, 23);
			end
			send_operands(a, b, gcd_lcm_of(a, b));
		end

		drain_results();
		repeat (LATENCY_CYCLES) @(posedge clk);

		if (mismatches == 0 && pending_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/gcdlcm_pkg.sv
sv/gcd_lcm_trial_division.sv
sim/gcd_lcm_trial_division_test.sv
